>>> rtl/core/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants of the ray to segment intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // Register stages ahead of the divider: line terms, products, line
    // constants, partial products, full products, numerators, magnitudes,
    // overflow check.
    localparam int FRONT_STAGES = 8;

endpackage

>>> rtl/core/ray_segment_intersect.sv
// ----------------------------------------------------------------------------
// ray_segment_intersect
// Fully pipelined 2D ray to line segment crossing test in signed fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_valid with the eight coordinates; the block raises
//   o_stall when it cannot take an item. Output channel: o_valid with
//   o_hit, o_cross_x, o_cross_y and o_parallel; the receiver raises i_stall.
//   One item enters per cycle and one result leaves per cycle as long as
//   the receiver does not stall.
//   The path runs through the front stages for line equations, wide
//   products and operand magnitudes, then one restoring divider stage per
//   quotient bit (x and y side by side), then the output register.
//   The quotient is truncated toward zero and saturated to COORD_BITS.
//   A zero determinant reports parallel with no hit and a zero point.
//   Reset clears all valid bits, including those of the output register and the skid stage.
//   When the receiver stalls, the result holds on the outputs; one more
//   result drops into a skid register, and o_stall then rises (driven from
//   that register only) and freezes the whole pipeline until it drains.
// ----------------------------------------------------------------------------
module ray_segment_intersect #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_ray_start_x,
    input  logic signed [COORD_BITS-1:0] i_ray_start_y,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_x,
    input  logic signed [COORD_BITS-1:0] i_ray_dir_y,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_cross_x,
    output logic signed [COORD_BITS-1:0] o_cross_y,
    output logic                         o_parallel
);

    localparam int C  = COORD_BITS;
    localparam int K  = C + 1;          // line coefficient width
    localparam int PW = 2 * C + 2;      // line constant width
    localparam int DW = 2 * C + 3;      // determinant width
    localparam int FW = 3 * K;          // full product width
    localparam int NW = 3 * C + 4;      // numerator width
    localparam int NS = rsi_pkg::FRONT_STAGES + C;

    typedef struct packed {
        logic signed [C-1:0] rx0;
        logic signed [C-1:0] ry0;
        logic                mx_pos;
        logic                mx_neg;
        logic                my_pos;
        logic                my_neg;
        logic signed [C-1:0] sx_lo;
        logic signed [C-1:0] sx_hi;
        logic signed [C-1:0] sy_lo;
        logic signed [C-1:0] sy_hi;
    } t_side;

    logic          pipe_en;
    logic [NS-1:0] r_v;
    logic          r_o_valid, r_skid_valid;

    // Advance the whole pipeline unless the skid stage holds an item
    assign pipe_en = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // ---------------------------------------------------------------- valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (pipe_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    // ---------------------------------------------------- stage 1: line terms
    logic signed [K-1:0] r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [C-1:0] r1_sx0, r1_sy0;
    t_side               r1_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_a1  <= K'(i_ray_dir_y) - K'(i_ray_start_y);
            r1_b1  <= K'(i_ray_start_x) - K'(i_ray_dir_x);
            r1_a2  <= K'(i_seg_end_y) - K'(i_seg_start_y);
            r1_b2  <= K'(i_seg_start_x) - K'(i_seg_end_x);
            r1_sx0 <= i_seg_start_x;
            r1_sy0 <= i_seg_start_y;
            r1_sd.rx0    <= i_ray_start_x;
            r1_sd.ry0    <= i_ray_start_y;
            r1_sd.mx_pos <= i_ray_start_x < i_ray_dir_x;
            r1_sd.mx_neg <= i_ray_start_x > i_ray_dir_x;
            r1_sd.my_pos <= i_ray_start_y < i_ray_dir_y;
            r1_sd.my_neg <= i_ray_start_y > i_ray_dir_y;
            r1_sd.sx_lo  <= (i_seg_start_x < i_seg_end_x) ? i_seg_start_x : i_seg_end_x;
            r1_sd.sx_hi  <= (i_seg_start_x > i_seg_end_x) ? i_seg_start_x : i_seg_end_x;
            r1_sd.sy_lo  <= (i_seg_start_y < i_seg_end_y) ? i_seg_start_y : i_seg_end_y;
            r1_sd.sy_hi  <= (i_seg_start_y > i_seg_end_y) ? i_seg_start_y : i_seg_end_y;
        end
    end

    // ------------------------------------------------------ stage 2: products
    logic signed [2*C:0]   r2_a1x, r2_b1y, r2_a2x, r2_b2y;
    logic signed [2*K-1:0] r2_a1b2, r2_a2b1;
    logic signed [K-1:0]   r2_a1, r2_b1, r2_a2, r2_b2;
    t_side                 r2_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_a1x  <= r1_a1 * r1_sd.rx0;
            r2_b1y  <= r1_b1 * r1_sd.ry0;
            r2_a2x  <= r1_a2 * r1_sx0;
            r2_b2y  <= r1_b2 * r1_sy0;
            r2_a1b2 <= r1_a1 * r1_b2;
            r2_a2b1 <= r1_a2 * r1_b1;
            r2_a1   <= r1_a1;
            r2_b1   <= r1_b1;
            r2_a2   <= r1_a2;
            r2_b2   <= r1_b2;
            r2_sd   <= r1_sd;
        end
    end

    // ---------------------------------- stage 3: line constants, determinant
    logic signed [PW-1:0] r3_c1, r3_c2;
    logic signed [DW-1:0] r3_det;
    logic signed [K-1:0]  r3_a1, r3_b1, r3_a2, r3_b2;
    t_side                r3_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_c1  <= PW'(r2_a1x) + PW'(r2_b1y);
            r3_c2  <= PW'(r2_a2x) + PW'(r2_b2y);
            r3_det <= DW'(r2_a1b2) - DW'(r2_a2b1);
            r3_a1  <= r2_a1;
            r3_b1  <= r2_b1;
            r3_a2  <= r2_a2;
            r3_b2  <= r2_b2;
            r3_sd  <= r2_sd;
        end
    end

    // --------------------------- stage 4: partial products on split constants
    logic signed [K-1:0]   c1_hi, c2_hi;
    logic signed [K:0]     c1_lo, c2_lo;
    logic signed [2*K-1:0] r4_b2c1_h, r4_b1c2_h, r4_a1c2_h, r4_a2c1_h;
    logic signed [2*K:0]   r4_b2c1_l, r4_b1c2_l, r4_a1c2_l, r4_a2c1_l;
    logic signed [DW-1:0]  r4_det;
    logic                  r4_par;
    t_side                 r4_sd;

    assign c1_hi = r3_c1[PW-1:K];
    assign c2_hi = r3_c2[PW-1:K];
    assign c1_lo = $signed({1'b0, r3_c1[K-1:0]});
    assign c2_lo = $signed({1'b0, r3_c2[K-1:0]});

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_b2c1_h <= r3_b2 * c1_hi;
            r4_b2c1_l <= r3_b2 * c1_lo;
            r4_b1c2_h <= r3_b1 * c2_hi;
            r4_b1c2_l <= r3_b1 * c2_lo;
            r4_a1c2_h <= r3_a1 * c2_hi;
            r4_a1c2_l <= r3_a1 * c2_lo;
            r4_a2c1_h <= r3_a2 * c1_hi;
            r4_a2c1_l <= r3_a2 * c1_lo;
            r4_det    <= r3_det;
            r4_par    <= r3_det == '0;
            r4_sd     <= r3_sd;
        end
    end

    // -------------------------------------------------- stage 5: full products
    logic signed [FW-1:0] r5_b2c1, r5_b1c2, r5_a1c2, r5_a2c1;
    logic signed [DW-1:0] r5_det;
    logic                 r5_par;
    t_side                r5_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_b2c1 <= (FW'(r4_b2c1_h) <<< K) + FW'(r4_b2c1_l);
            r5_b1c2 <= (FW'(r4_b1c2_h) <<< K) + FW'(r4_b1c2_l);
            r5_a1c2 <= (FW'(r4_a1c2_h) <<< K) + FW'(r4_a1c2_l);
            r5_a2c1 <= (FW'(r4_a2c1_h) <<< K) + FW'(r4_a2c1_l);
            r5_det  <= r4_det;
            r5_par  <= r4_par;
            r5_sd   <= r4_sd;
        end
    end

    // ----------------------------------------------------- stage 6: numerators
    logic signed [NW-1:0] r6_nx, r6_ny;
    logic signed [DW-1:0] r6_det;
    logic                 r6_par;
    t_side                r6_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r6_nx  <= NW'(r5_b2c1) - NW'(r5_b1c2);
            r6_ny  <= NW'(r5_a1c2) - NW'(r5_a2c1);
            r6_det <= r5_det;
            r6_par <= r5_par;
            r6_sd  <= r5_sd;
        end
    end

    // ----------------------------------------------------- stage 7: magnitudes
    logic [NW-1:0] r7_mx, r7_my;
    logic [DW-1:0] r7_md;
    logic          r7_sgx, r7_sgy, r7_par;
    t_side         r7_sd;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r7_mx  <= r6_nx[NW-1] ? $unsigned(-r6_nx) : $unsigned(r6_nx);
            r7_my  <= r6_ny[NW-1] ? $unsigned(-r6_ny) : $unsigned(r6_ny);
            r7_md  <= r6_det[DW-1] ? $unsigned(-r6_det) : $unsigned(r6_det);
            r7_sgx <= r6_nx[NW-1] ^ r6_det[DW-1];
            r7_sgy <= r6_ny[NW-1] ^ r6_det[DW-1];
            r7_par <= r6_par;
            r7_sd  <= r6_sd;
        end
    end

    // ---------------- stage 8 and divider: one quotient bit per stage
    logic [NW-1:0] r_remx [0:C];
    logic [NW-1:0] r_remy [0:C];
    logic [C-1:0]  r_qx   [0:C];
    logic [C-1:0]  r_qy   [0:C];
    logic [DW-1:0] r_d    [0:C];
    logic          r_sgx  [0:C];
    logic          r_sgy  [0:C];
    logic          r_ovx  [0:C];
    logic          r_ovy  [0:C];
    logic          r_par  [0:C];
    t_side         r_sd   [0:C];
    logic [NW-1:0] d_top;

    assign d_top = NW'(r7_md) << C;

    // Flag quotients of COORD_BITS+1 bits or more, they always saturate
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_remx[0] <= r7_mx;
            r_remy[0] <= r7_my;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_d[0]    <= r7_md;
            r_sgx[0]  <= r7_sgx;
            r_sgy[0]  <= r7_sgy;
            r_ovx[0]  <= r7_mx >= d_top;
            r_ovy[0]  <= r7_my >= d_top;
            r_par[0]  <= r7_par;
            r_sd[0]   <= r7_sd;
        end
    end

    for (genvar j = 0; j < C; j++) begin : g_div
        localparam int B = C - 1 - j;
        logic [NW-1:0] dsh;
        logic [NW:0]   tx, ty;

        // Trial subtract of the shifted divisor on both axes
        assign dsh = NW'(r_d[j]) << B;
        assign tx  = {1'b0, r_remx[j]} - {1'b0, dsh};
        assign ty  = {1'b0, r_remy[j]} - {1'b0, dsh};

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_remx[j+1] <= tx[NW] ? r_remx[j] : tx[NW-1:0];
                r_remy[j+1] <= ty[NW] ? r_remy[j] : ty[NW-1:0];
                r_qx[j+1]   <= r_qx[j] | (C'(!tx[NW]) << B);
                r_qy[j+1]   <= r_qy[j] | (C'(!ty[NW]) << B);
                r_d[j+1]    <= r_d[j];
                r_sgx[j+1]  <= r_sgx[j];
                r_sgy[j+1]  <= r_sgy[j];
                r_ovx[j+1]  <= r_ovx[j];
                r_ovy[j+1]  <= r_ovy[j];
                r_par[j+1]  <= r_par[j];
                r_sd[j+1]   <= r_sd[j];
            end
        end
    end

    // ------------------------------------------- sign, saturate and hit test
    localparam logic signed [C-1:0] SAT_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] SAT_MIN = {1'b1, {(C-1){1'b0}}};

    logic [C-1:0]        qx, qy;
    logic signed [C-1:0] sat_x, sat_y, cx, cy;
    logic                in_ray, in_box, t_hit;
    t_side               sd;

    assign qx = r_qx[C];
    assign qy = r_qy[C];
    assign sd = r_sd[C];

    always_comb begin
        if (r_sgx[C]) begin
            sat_x = (r_ovx[C] || (qx[C-1] && |qx[C-2:0])) ? SAT_MIN : $signed(~qx + 1'b1);
        end else begin
            sat_x = (r_ovx[C] || qx[C-1]) ? SAT_MAX : $signed(qx);
        end
        if (r_sgy[C]) begin
            sat_y = (r_ovy[C] || (qy[C-1] && |qy[C-2:0])) ? SAT_MIN : $signed(~qy + 1'b1);
        end else begin
            sat_y = (r_ovy[C] || qy[C-1]) ? SAT_MAX : $signed(qy);
        end
        in_ray = (!sd.mx_pos || sat_x >= sd.rx0) && (!sd.mx_neg || sat_x <= sd.rx0) &&
                 (!sd.my_pos || sat_y >= sd.ry0) && (!sd.my_neg || sat_y <= sd.ry0);
        in_box = sd.sx_lo <= sat_x && sat_x <= sd.sx_hi &&
                 sd.sy_lo <= sat_y && sat_y <= sd.sy_hi;
        cx     = r_par[C] ? '0 : sat_x;
        cy     = r_par[C] ? '0 : sat_y;
        t_hit  = !r_par[C] && in_ray && in_box;
    end

    // ---------------------------------------------- output register and skid
    logic                r_o_hit, r_o_par, r_k_hit, r_k_par;
    logic signed [C-1:0] r_o_x, r_o_y, r_k_x, r_k_y;
    logic                out_free, tail_v;

    assign out_free = !r_o_valid || !i_stall;
    assign tail_v   = r_v[NS-1];

    // Track occupancy of the output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid    <= r_skid_valid || tail_v;
            r_skid_valid <= 1'b0;
        end else if (tail_v && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Move payload: skid drains first, then the pipeline tail
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_o_hit <= r_k_hit;
                r_o_par <= r_k_par;
                r_o_x   <= r_k_x;
                r_o_y   <= r_k_y;
            end else begin
                r_o_hit <= t_hit;
                r_o_par <= r_par[C];
                r_o_x   <= cx;
                r_o_y   <= cy;
            end
        end else if (!r_skid_valid) begin
            r_k_hit <= t_hit;
            r_k_par <= r_par[C];
            r_k_x   <= cx;
            r_k_y   <= cy;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_hit      = r_o_hit;
    assign o_parallel = r_o_par;
    assign o_cross_x  = r_o_x;
    assign o_cross_y  = r_o_y;

    // ------------------------------------------------------------ assertions
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_o_valid)
        else $error("skid holds an item while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_o_valid && i_stall && r_v[NS-1]))
        else $error("skid filled without a stalled output");

    a_parallel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parallel) |-> (!o_hit && o_cross_x == '0 && o_cross_y == '0))
        else $error("parallel result carries a hit or a point");

    a_freeze_on_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(r_v) || !$past(r_skid_valid))
        else $error("pipeline moved while the skid was full");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ray_segment_intersect: directed corner cases and
// random rays and segments, random gaps on both channels, one long output
// hold-off that fills the pipeline, and an in-order scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW = 24;
    localparam int N_RANDOM = 1300;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t rx0, ry0, rx1, ry1, sx0, sy0, sx1, sy1;
    } query_t;

    typedef struct packed {
        logic   hit;
        coord_t cx;
        coord_t cy;
        logic   par;
    } crossing_t;

    // Scoreboard: predicts each crossing and checks results in order.
    class crossing_board;
        crossing_t pending[$];
        int        errors;

        function automatic logic signed [CW-1:0] quot_sat(
                logic signed [127:0] num, logic signed [127:0] den);
            logic signed [127:0] q;
            logic signed [127:0] lo;
            logic signed [127:0] hi;
            q  = num / den;
            hi = (128'sd1 <<< (CW - 1)) - 1;
            lo = -(128'sd1 <<< (CW - 1));
            if (q > hi) q = hi;
            if (q < lo) q = lo;
            return q[CW-1:0];
        endfunction

        function automatic void note_query(query_t t);
            logic signed [127:0] a1, b1, a2, b2, c1, c2, det;
            logic signed [63:0]  rx0, ry0, rx1, ry1, sx0, sy0, sx1, sy1, x, y;
            crossing_t e;
            rx0 = t.rx0; ry0 = t.ry0; rx1 = t.rx1; ry1 = t.ry1;
            sx0 = t.sx0; sy0 = t.sy0; sx1 = t.sx1; sy1 = t.sy1;
            a1  = ry1 - ry0;
            b1  = rx0 - rx1;
            a2  = sy1 - sy0;
            b2  = sx0 - sx1;
            c1  = a1 * rx0 + b1 * ry0;
            c2  = a2 * sx0 + b2 * sy0;
            det = a1 * b2 - a2 * b1;
            e   = '0;
            if (det == 0) begin
                e.par = 1'b1;
            end else begin
                e.cx = quot_sat(b2 * c1 - b1 * c2, det);
                e.cy = quot_sat(a1 * c2 - a2 * c1, det);
                x = e.cx;
                y = e.cy;
                e.hit = 1'b1;
                if (rx0 < rx1 && x < rx0) e.hit = 1'b0;
                if (rx0 > rx1 && x > rx0) e.hit = 1'b0;
                if (ry0 < ry1 && y < ry0) e.hit = 1'b0;
                if (ry0 > ry1 && y > ry0) e.hit = 1'b0;
                if (x < (sx0 < sx1 ? sx0 : sx1) || x > (sx0 > sx1 ? sx0 : sx1))
                    e.hit = 1'b0;
                if (y < (sy0 < sy1 ? sy0 : sy1) || y > (sy0 > sy1 ? sy0 : sy1))
                    e.hit = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function automatic void check_result(crossing_t got);
            crossing_t e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit: expected %0d actual %0d", e.hit, got.hit);
                errors++;
            end
            if (got.cx !== e.cx) begin
                $error("cross_x: expected %0d actual %0d", e.cx, got.cx);
                errors++;
            end
            if (got.cy !== e.cy) begin
                $error("cross_y: expected %0d actual %0d", e.cy, got.cy);
                errors++;
            end
            if (got.par !== e.par) begin
                $error("parallel: expected %0d actual %0d", e.par, got.par);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b1;
    query_t query = '0;
    logic   o_stall, o_valid, o_hit, o_parallel;
    coord_t o_cross_x, o_cross_y;

    crossing_board board = new();
    bit     stim_done = 1'b0;
    bit     hold_off = 1'b0;
    int     idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    ray_segment_intersect #(.COORD_BITS(CW)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ray_start_x (query.rx0),
        .i_ray_start_y (query.ry0),
        .i_ray_dir_x   (query.rx1),
        .i_ray_dir_y   (query.ry1),
        .i_seg_start_x (query.sx0),
        .i_seg_start_y (query.sy0),
        .i_seg_end_x   (query.sx1),
        .i_seg_end_y   (query.sy1),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_cross_x     (o_cross_x),
        .o_cross_y     (o_cross_y),
        .o_parallel    (o_parallel)
    );

    function automatic int gap_len();
        if ($urandom_range(99) < 60) return 0;
        if ($urandom_range(99) < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(2000)) - 1000);
            2: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return coord_t'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    // Ray from a random start towards a point, segment spanning a line
    // through a chosen spot; gives a good share of hits.
    function automatic query_t rand_query();
        query_t t;
        int     px, py, k;
        t.rx0 = rand_coord(); t.ry0 = rand_coord();
        t.rx1 = rand_coord(); t.ry1 = rand_coord();
        t.sx0 = rand_coord(); t.sy0 = rand_coord();
        t.sx1 = rand_coord(); t.sy1 = rand_coord();
        k = $urandom_range(9);
        if (k < 6) begin
            px = $signed($urandom_range(100000)) - 50000;
            py = $signed($urandom_range(100000)) - 50000;
            t.rx0 = coord_t'(px - ($signed($urandom_range(20000)) - 10000));
            t.ry0 = coord_t'(py - ($signed($urandom_range(20000)) - 10000));
            t.rx1 = coord_t'(px); t.ry1 = coord_t'(py);
            k = $signed($urandom_range(20000)) - 10000;
            t.sx0 = coord_t'(px - k);
            t.sx1 = coord_t'(px + k + $signed($urandom_range(4)) - 2);
            k = $signed($urandom_range(20000)) - 10000;
            t.sy0 = coord_t'(py - k);
            t.sy1 = coord_t'(py + k + $signed($urandom_range(4)) - 2);
        end else if (k == 6) begin
            // parallel: segment direction copies the ray direction
            t.sx1 = t.sx0 + (t.rx1 - t.rx0);
            t.sy1 = t.sy0 + (t.ry1 - t.ry0);
        end else if (k == 7) begin
            // axis-aligned ray
            if ($urandom_range(1)) t.rx1 = t.rx0; else t.ry1 = t.ry0;
        end
        return t;
    endfunction

    // Offer one item and hold it until accepted.
    task automatic send_query(query_t t);
        int g;
        g = gap_len();
        // Drop valid over the gap so the last item is not offered twice
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        board.note_query(t);
        query   <= t;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_directed();
        query_t t;
        // crossing at the origin, hit
        t = '{-24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd0, -24'sd256, 24'sd0, 24'sd256};
        send_query(t);
        // crossing behind the ray start
        t = '{24'sd256, 24'sd0, 24'sd512, 24'sd0, 24'sd0, -24'sd256, 24'sd0, 24'sd256};
        send_query(t);
        // parallel lines
        t = '{24'sd0, 24'sd0, 24'sd256, 24'sd256, 24'sd0, 24'sd100, 24'sd256, 24'sd356};
        send_query(t);
        // degenerate ray and degenerate segment
        t = '{24'sd5, 24'sd5, 24'sd5, 24'sd5, 24'sd0, 24'sd0, 24'sd9, 24'sd9};
        send_query(t);
        t = '{24'sd0, 24'sd0, 24'sd9, 24'sd1, 24'sd3, 24'sd3, 24'sd3, 24'sd3};
        send_query(t);
        // ray not moving in x, then not moving in y
        t = '{24'sd10, -24'sd500, 24'sd10, -24'sd400, -24'sd50, 24'sd0, 24'sd50, 24'sd0};
        send_query(t);
        t = '{24'sd500, 24'sd7, 24'sd400, 24'sd7, 24'sd0, -24'sd50, 24'sd0, 24'sd50};
        send_query(t);
        // extremes: far crossings that saturate both ways
        t = '{24'sh800000, 24'sh800000, 24'sh800001, 24'sh7fffff,
              24'sh7fffff, 24'sh800000, 24'sh7ffffe, 24'sh7fffff};
        send_query(t);
        t = '{24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000,
              24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000};
        send_query(t);
        t = '{24'sd0, 24'sd0, 24'sd1, 24'sd1, 24'sh7fffff, 24'sd0, 24'sh7fffff, 24'sd1};
        send_query(t);
        t = '{24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555,
              24'sh0f0f0f, 24'shf0f0f0, 24'shf0f0f0, 24'sh0f0f0f};
        send_query(t);
        t = '{24'shffffff, 24'sd0, 24'sd0, 24'shffffff,
              24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff};
        send_query(t);
    endtask

    // Stimulus: reset, directed, a burst under a long hold-off, random.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_directed();
        hold_off = 1'b1;
        repeat (60) begin
            query_t t;
            t = rand_query();
            board.note_query(t);
            query   <= t;
            i_valid <= 1'b1;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        for (int n = 0; n < N_RANDOM; n++) send_query(rand_query());
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver stall: long hold-off once, otherwise random gaps.
    initial begin
        int g;
        @(posedge i_rst_n);
        i_stall <= 1'b0;
        wait (hold_off);
        @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (200) @(posedge i_clk);
        i_stall <= 1'b0;
        forever begin
            g = gap_len();
            if (g > 0) begin
                i_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
    end

    // Check results at each accepting edge; watchdog on idle cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_result('{o_hit, o_cross_x, o_cross_y, o_parallel});
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // End of run
    initial begin
        wait (stim_done && board.pending.size() == 0 || idle_cycles >= WATCHDOG_LIMIT);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
        end else begin
            repeat (60) @(posedge i_clk);
            if (board.errors == 0 && board.pending.size() == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/rsi_pkg.sv
rtl/core/ray_segment_intersect.sv
sim/tb_top.sv
